### hdl/usd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared transfer types, the work descriptor and the byte class constants.
// ----------------------------------------------------------------------------
`default_nettype none

package usd_pkg;

   localparam logic [7:0]  CONT_MASK    = 8'hC0;
   localparam logic [7:0]  CONT_TAG     = 8'h80;
   localparam logic [7:0]  PAYLOAD_MASK = 8'h3F;
   localparam logic [7:0]  ASCII_MASK   = 8'h7F;
   localparam logic [20:0] BOM_VALUE    = 21'h00FEFF;

   localparam logic [2:0]  SEQ_LEN_NONE = 3'd0;
   localparam logic [2:0]  SEQ_LEN_TWO  = 3'd2;
   localparam logic [2:0]  SEQ_LEN_THREE = 3'd3;
   localparam logic [2:0]  SEQ_LEN_FOUR = 3'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        invalid;
      logic        is_bom;
      logic        last_of_run;
      logic        stream_done;
   } rsp_type;

   // Results of one byte: inv_count invalid results, then one valid result
   // when has_valid is set.
   typedef struct packed {
      logic [2:0]  inv_count;
      logic        has_valid;
      logic [20:0] code_point;
      logic        eos;
   } desc_type;

endpackage

`default_nettype wire

### hdl/usd_front.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder front end
// Accepts one byte per transfer, tracks the partial sequence and turns each
// byte that causes results into a descriptor of those results.
// ----------------------------------------------------------------------------
`default_nettype none

module usd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire usd_pkg::req_type req_payload,
   input  wire logic             queue_full,
   output logic                  push,
   output usd_pkg::desc_type     push_desc
);

   logic [20:0] partial_ff, partial_in;
   logic [2:0]  exp_len_ff, exp_len_in;
   logic [1:0]  held_ff, held_in;

   logic [7:0]  b;
   logic        eos;
   logic        is_cont;
   logic        consumed;
   logic        accept;
   logic [20:0] shifted;
   logic [2:0]  held_plus_one;
   logic [2:0]  inv_count;
   logic        has_valid;
   logic [20:0] code_point;

   assign b       = req_payload.data_byte;
   assign eos     = req_payload.end_of_stream;
   assign is_cont = (b & usd_pkg::CONT_MASK) == usd_pkg::CONT_TAG;
   assign shifted = {partial_ff[14:0], 6'(b & usd_pkg::PAYLOAD_MASK)};
   assign held_plus_one = {1'b0, held_ff} + 3'd1;

   always_comb begin
      partial_in = partial_ff;
      exp_len_in = exp_len_ff;
      held_in    = held_ff;
      inv_count  = 3'd0;
      has_valid  = 1'b0;
      code_point = 21'd0;
      consumed   = 1'b0;

      if (exp_len_ff != usd_pkg::SEQ_LEN_NONE) begin
         if (is_cont) begin
            consumed = 1'b1;
            if (held_plus_one >= exp_len_ff) begin
               has_valid  = 1'b1;
               code_point = shifted;
               partial_in = 21'd0;
               exp_len_in = usd_pkg::SEQ_LEN_NONE;
               held_in    = 2'd0;
            end else begin
               partial_in = shifted;
               held_in    = held_plus_one[1:0];
            end
         end else begin
            inv_count  = {1'b0, held_ff};
            partial_in = 21'd0;
            exp_len_in = usd_pkg::SEQ_LEN_NONE;
            held_in    = 2'd0;
         end
      end

      if (!consumed) begin
         if (!b[7]) begin
            has_valid  = 1'b1;
            code_point = {13'd0, b & usd_pkg::ASCII_MASK};
         end else if (!b[6]) begin
            inv_count = inv_count + 3'd1;
         end else if (!b[5]) begin
            partial_in = {16'd0, b[4:0]};
            exp_len_in = usd_pkg::SEQ_LEN_TWO;
            held_in    = 2'd1;
         end else if (!b[4]) begin
            partial_in = {17'd0, b[3:0]};
            exp_len_in = usd_pkg::SEQ_LEN_THREE;
            held_in    = 2'd1;
         end else if (!b[3]) begin
            partial_in = {18'd0, b[2:0]};
            exp_len_in = usd_pkg::SEQ_LEN_FOUR;
            held_in    = 2'd1;
         end else begin
            inv_count = inv_count + 3'd1;
         end
      end

      if (eos && (exp_len_in != usd_pkg::SEQ_LEN_NONE)) begin
         inv_count  = inv_count + {1'b0, held_in};
         partial_in = 21'd0;
         exp_len_in = usd_pkg::SEQ_LEN_NONE;
         held_in    = 2'd0;
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && ((inv_count != 3'd0) || has_valid);

   assign push_desc.inv_count  = inv_count;
   assign push_desc.has_valid  = has_valid;
   assign push_desc.code_point = code_point;
   assign push_desc.eos        = eos;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 21'd0;
         exp_len_ff <= usd_pkg::SEQ_LEN_NONE;
         held_ff    <= 2'd0;
      end else if (accept) begin
         partial_ff <= partial_in;
         exp_len_ff <= exp_len_in;
         held_ff    <= held_in;
      end
   end

endmodule

`default_nettype wire

### hdl/usd_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder descriptor queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module usd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire usd_pkg::desc_type push_desc,
   output logic                   full,
   output logic                   head_valid,
   output usd_pkg::desc_type      head_desc,
   input  wire logic              pop
);

   usd_pkg::desc_type entry_ff [usd_pkg::QUEUE_DEPTH];

   logic [usd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [usd_pkg::QUEUE_CNT_W-1:0] count_ff;

   assign full       = count_ff == usd_pkg::QUEUE_CNT_W'(usd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == usd_pkg::QUEUE_PTR_W'(usd_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == usd_pkg::QUEUE_PTR_W'(usd_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/usd_back.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder back end
// Expands the descriptor at the queue head into result transfers, one per
// cycle unless the output is stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module usd_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire usd_pkg::desc_type head_desc,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output usd_pkg::rsp_type       rsp_payload
);

   logic [2:0]       idx_ff;
   logic             rsp_valid_ff;
   usd_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   logic [2:0] total;
   logic       emit_inv;
   logic       last;
   logic       load;

   assign total    = head_desc.inv_count + {2'b00, head_desc.has_valid};
   assign emit_inv = idx_ff < head_desc.inv_count;
   assign last     = (idx_ff + 3'd1) == total;
   assign load     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop      = load && last;

   always_comb begin
      rsp_payload_in.code_point  = emit_inv ? 21'd0 : head_desc.code_point;
      rsp_payload_in.invalid     = emit_inv;
      rsp_payload_in.is_bom      = !emit_inv && (head_desc.code_point == usd_pkg::BOM_VALUE);
      rsp_payload_in.last_of_run = last;
      rsp_payload_in.stream_done = last && head_desc.eos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            idx_ff       <= last ? 3'd0 : idx_ff + 3'd1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### hdl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes a byte stream into code points with invalid, BOM and run flags.
//
//   Channel   Direction  Handshake             Payload
//   req_*     in         req_valid/req_stall   usd_pkg::req_type (one byte)
//   rsp_*     out        rsp_valid/rsp_stall   usd_pkg::rsp_type (one result)
//
// The front end takes one byte per cycle while the descriptor queue has room.
// The back end sends one result per cycle while the output is not stalled, so
// a byte causing several results holds the output until all of them are sent;
// the two-entry queue absorbs the difference. Each result is registered in the queue and then in the output stage.
// Reset is synchronous and clears the held sequence, the queue and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire usd_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output usd_pkg::rsp_type      rsp_payload
);

   logic              push;
   usd_pkg::desc_type push_desc;
   logic              queue_full;
   logic              head_valid;
   usd_pkg::desc_type head_desc;
   logic              pop;

   usd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_desc   (push_desc)
   );

   usd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop)
   );

   usd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_desc   (head_desc),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### test/utf8_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives directed and random byte streams through the decoder. A local
// decoder model predicts every result of each accepted byte. The checker
// compares each result transfer with the oldest prediction. Both channels
// idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_tb;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   usd_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   usd_pkg::rsp_type rsp_payload;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   event hold_kick;

   logic [20:0]      seq_value = '0;
   logic [2:0]       seq_len = usd_pkg::SEQ_LEN_NONE;
   int               seq_count = 0;
   usd_pkg::rsp_type byte_results[$];
   usd_pkg::rsp_type decoded_q[$];

   utf8_stream_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("utf8_stream_decoder verification failed");
      $finish;
   end

   function automatic void add_result(input logic [20:0] value, input logic bad);
      usd_pkg::rsp_type r;
      r.code_point  = bad ? 21'd0 : value;
      r.invalid     = bad;
      r.is_bom      = !bad && (value == usd_pkg::BOM_VALUE);
      r.last_of_run = 1'b0;
      r.stream_done = 1'b0;
      byte_results.push_back(r);
   endfunction

   function automatic void flush_partial();
      for (int i = 0; i < seq_count; i++) begin
         add_result(21'd0, 1'b1);
      end
      seq_value = '0;
      seq_len   = usd_pkg::SEQ_LEN_NONE;
      seq_count = 0;
   endfunction

   function automatic void open_sequence(input logic [20:0] payload, input logic [2:0] len);
      seq_value = payload;
      seq_len   = len;
      seq_count = 1;
   endfunction

   function automatic void decode_byte(input logic [7:0] b, input logic eos);
      logic consumed;
      consumed = 1'b0;
      byte_results.delete();
      if (seq_len != usd_pkg::SEQ_LEN_NONE) begin
         if ((b & usd_pkg::CONT_MASK) == usd_pkg::CONT_TAG) begin
            seq_value = {seq_value[14:0], b[5:0]};
            seq_count++;
            if (seq_count >= seq_len) begin
               add_result(seq_value, 1'b0);
               seq_value = '0;
               seq_len   = usd_pkg::SEQ_LEN_NONE;
               seq_count = 0;
            end
            consumed = 1'b1;
         end else begin
            flush_partial();
         end
      end
      if (!consumed) begin
         if (b < 8'h80) begin
            add_result({13'd0, b & usd_pkg::ASCII_MASK}, 1'b0);
         end else if (b < 8'hC0) begin
            add_result(21'd0, 1'b1);
         end else if (b < 8'hE0) begin
            open_sequence({16'd0, b[4:0]}, usd_pkg::SEQ_LEN_TWO);
         end else if (b < 8'hF0) begin
            open_sequence({17'd0, b[3:0]}, usd_pkg::SEQ_LEN_THREE);
         end else if (b < 8'hF8) begin
            open_sequence({18'd0, b[2:0]}, usd_pkg::SEQ_LEN_FOUR);
         end else begin
            add_result(21'd0, 1'b1);
         end
      end
      if (eos && seq_len != usd_pkg::SEQ_LEN_NONE) begin
         flush_partial();
      end
      if (byte_results.size() > 0) begin
         byte_results[byte_results.size() - 1].last_of_run = 1'b1;
         byte_results[byte_results.size() - 1].stream_done = eos;
      end
      foreach (byte_results[i]) begin
         decoded_q.push_back(byte_results[i]);
      end
   endfunction

   // Call only right after a rising clock edge.
   task automatic send_byte(input logic [7:0] b, input logic eos = 1'b0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, end_of_stream: eos};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      decode_byte(b, eos);
   endtask

   function automatic logic [7:0] lead_byte(input int len);
      case (len)
         2: begin
            return 8'hC0 | 8'($urandom_range(31));
         end
         3: begin
            return 8'hE0 | 8'($urandom_range(15));
         end
         default: begin
            return 8'hF0 | 8'($urandom_range(7));
         end
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return usd_pkg::CONT_TAG | 8'($urandom_range(63));
   endfunction

   always @(posedge clock) begin
      usd_pkg::rsp_type want;
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result transfer: cp=%h inv=%b bom=%b last=%b done=%b",
                        rsp_payload.code_point, rsp_payload.invalid, rsp_payload.is_bom,
                        rsp_payload.last_of_run, rsp_payload.stream_done);
            end
         end else begin
            want = decoded_q.pop_front();
            if (rsp_payload.code_point !== want.code_point ||
                rsp_payload.invalid !== want.invalid ||
                rsp_payload.is_bom !== want.is_bom ||
                rsp_payload.last_of_run !== want.last_of_run ||
                rsp_payload.stream_done !== want.stream_done) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected cp=%h inv=%b bom=%b last=%b done=%b",
                           want.code_point, want.invalid, want.is_bom,
                           want.last_of_run, want.stream_done);
                  $display("          actual   cp=%h inv=%b bom=%b last=%b done=%b",
                           rsp_payload.code_point, rsp_payload.invalid, rsp_payload.is_bom,
                           rsp_payload.last_of_run, rsp_payload.stream_done);
               end
            end
         end
      end
   end

   always begin
      @(hold_kick);
      hold_left = 200;
      while (hold_left > 0) begin
         @(posedge clock);
         hold_left--;
      end
   end

   task automatic test_ascii_and_nul();
      send_byte(8'h00);
      send_byte(8'h7F);
   endtask

   task automatic test_stray_and_bad_lead();
      send_byte(8'h80);
      send_byte(8'hFF);
      send_byte(8'hF8);
   endtask

   task automatic test_multibyte();
      send_byte(8'hC2);
      send_byte(8'hA9);
      send_byte(8'hF7);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'hEF);
      send_byte(8'hBB);
      send_byte(8'hBF);
   endtask

   task automatic test_broken_sequence();
      send_byte(8'hE2);
      send_byte(8'h82);
      send_byte(8'h41);
      send_byte(8'hF0);
      send_byte(8'h90);
      send_byte(8'h80);
      send_byte(8'hFF);
   endtask

   task automatic test_end_of_stream();
      send_byte(8'hF0);
      send_byte(8'h90, 1'b1);
      send_byte(8'hC3, 1'b1);
      send_byte(8'h80, 1'b1);
   endtask

   task automatic test_random_stream(input int n_items);
      int sent;
      int kind;
      int len;
      int cut;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 25) begin
            send_byte(8'($urandom_range(127)), $urandom_range(49) == 0);
            sent++;
         end else if (kind < 75) begin
            len = $urandom_range(4, 2);
            if (len == 3 && $urandom_range(9) == 0) begin
               send_byte(8'hEF);
               send_byte(8'hBB);
               send_byte(8'hBF, $urandom_range(49) == 0);
            end else begin
               send_byte(lead_byte(len));
               for (int i = 1; i < len; i++) begin
                  send_byte(cont_byte(), (i == len - 1) && ($urandom_range(49) == 0));
               end
            end
            sent += len;
         end else if (kind < 88) begin
            len = $urandom_range(4, 2);
            cut = $urandom_range(len - 1, 1);
            send_byte(lead_byte(len), cut == 1 && $urandom_range(7) == 0);
            for (int i = 1; i < cut; i++) begin
               send_byte(cont_byte(), (i == cut - 1) && ($urandom_range(7) == 0));
            end
            sent += cut;
         end else begin
            send_byte(8'($urandom_range(255)), $urandom_range(49) == 0);
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      -> hold_kick;
      for (int i = 0; i < 10; i++) begin
         send_byte(8'hF0);
         send_byte(8'h90);
         send_byte(8'h80);
         send_byte(8'hFF);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 85;
      test_ascii_and_nul();
      test_stray_and_bad_lead();
      test_multibyte();
      test_broken_sequence();
      test_end_of_stream();
      test_random_stream(80);

      send_idle_pct = 85;
      recv_idle_pct = 30;
      test_random_stream(80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_stream(80);
      test_backpressure();

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("utf8_stream_decoder verification clean");
      end else begin
         $display("utf8_stream_decoder verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### utf8_stream_decoder.f
hdl/usd_pkg.sv
hdl/usd_front.sv
hdl/usd_queue.sv
hdl/usd_back.sv
hdl/utf8_stream_decoder.sv
test/utf8_stream_decoder_tb.sv
